/* rtl/core/assert_macros.svh */
// Assertion macros used by the deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define BDQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in a cycle implies consequent in the next.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bdq_pkg.sv */
// Shared types and constants for the bounded deque with walk.
package bdq_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    typedef enum logic [2:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_WALK_BEGIN = 3'd3,
        REQ_WALK_NEXT  = 3'd4,
        REQ_WALK_END   = 3'd5
    } req_t;

    // Broadcast from the control to every cell of the chain.
    typedef struct packed {
        logic shift_right;
        logic load_tail;
        logic shift_left;
        logic walk_copy;
        logic walk_shift;
    } cell_ctrl_t;

endpackage

/* rtl/core/bdq_cell.sv */
// One cell of the deque chain: a stored entry and its walk copy.
module bdq_cell #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEFAULT,
    parameter int INDEX      = 0
) (
    input  logic                          clk,
    input  bdq_pkg::cell_ctrl_t           ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]    fill,
    input  logic [DATA_WIDTH-1:0]         new_data,
    input  logic [DATA_WIDTH-1:0]         left_data,
    input  logic [DATA_WIDTH-1:0]         right_data,
    input  logic [DATA_WIDTH-1:0]         right_walk,
    output logic [DATA_WIDTH-1:0]         data,
    output logic [DATA_WIDTH-1:0]         walk
);
    import bdq_pkg::*;

    localparam int FW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [DATA_WIDTH-1:0] walk_reg;
    logic [DATA_WIDTH-1:0] walk_next;
    logic                  is_tail;

    assign is_tail = (fill == FW'(INDEX));

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_right)
        begin
            data_next = left_data;
        end
        else if (ctrl.shift_left)
        begin
            data_next = right_data;
        end
        else if (ctrl.load_tail && is_tail)
        begin
            data_next = new_data;
        end
    end

    always_comb
    begin
        walk_next = walk_reg;
        if (ctrl.walk_copy)
        begin
            walk_next = data_reg;
        end
        else if (ctrl.walk_shift)
        begin
            walk_next = right_walk;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        walk_reg <= walk_next;
    end

    assign data = data_reg;
    assign walk = walk_reg;

endmodule

/* rtl/core/bounded_deque_with_walk.sv */
// Top level of the bounded deque with walk: request decode and cell chain.
//
//  Channel  Dir  tdata (low bit up)            tuser
//  s_axis   in   data_in                       req_type
//  m_axis   out  data_out, fill_level          ok
//
// One request is accepted per cycle; its result appears in the output
// register on the next cycle. The chain keeps the front entry in cell 0, so
// a push, pop or walk step is a shift, a tail load or a read of cell 0, and
// walk begin snapshots the chain. Input stalls only while a result waits in
// the output register and m_axis_tready is low. Reset clears the counters
// at once; cell contents are not cleared and no clearing pass runs.
`include "assert_macros.svh"

module bounded_deque_with_walk #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                                                     clk,
    input  logic                                                     rst_n,
    input  logic                                                     s_axis_tvalid,
    output logic                                                     s_axis_tready,
    // data_in
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]                          s_axis_tdata,
    // req_type
    input  logic [2:0]                                               s_axis_tuser,
    output logic                                                     m_axis_tvalid,
    input  logic                                                     m_axis_tready,
    // data_out, fill_level
    output logic [((DATA_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0]          m_axis_tdata,
    // ok
    output logic                                                     m_axis_tuser
);
    import bdq_pkg::*;

    localparam int FW = $clog2(DEPTH + 1);
    localparam int OW = ((DATA_WIDTH + FW + 7) / 8) * 8;

    logic                  accept;
    logic                  full;
    logic                  empty;
    req_t                  req;
    logic [DATA_WIDTH-1:0] data_in;
    cell_ctrl_t            ctrl;

    logic [FW-1:0]         fill_reg;
    logic [FW-1:0]         fill_next;
    logic [FW-1:0]         walk_left_reg;
    logic [FW-1:0]         walk_left_next;

    logic                  res_ok;
    logic [DATA_WIDTH-1:0] res_data;

    logic                  out_valid_reg;
    logic                  out_ok_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic [FW-1:0]         out_fill_reg;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] cell_walk [DEPTH];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign req           = req_t'(s_axis_tuser);
    assign data_in       = s_axis_tdata[DATA_WIDTH-1:0];
    assign full          = (fill_reg == FW'(DEPTH));
    assign empty         = (fill_reg == '0);

    always_comb
    begin
        ctrl           = '0;
        fill_next      = fill_reg;
        walk_left_next = walk_left_reg;
        res_ok         = 1'b0;
        res_data       = '0;
        if (accept)
        begin
            case (req)
                REQ_PUSH_BACK:
                begin
                    walk_left_next = '0;
                    if (!full)
                    begin
                        ctrl.load_tail = 1'b1;
                        fill_next      = fill_reg + 1'b1;
                        res_ok         = 1'b1;
                    end
                end
                REQ_PUSH_FRONT:
                begin
                    walk_left_next = '0;
                    if (!full)
                    begin
                        ctrl.shift_right = 1'b1;
                        fill_next        = fill_reg + 1'b1;
                        res_ok           = 1'b1;
                    end
                end
                REQ_POP_FRONT:
                begin
                    walk_left_next = '0;
                    if (!empty)
                    begin
                        ctrl.shift_left = 1'b1;
                        fill_next       = fill_reg - 1'b1;
                        res_ok          = 1'b1;
                        res_data        = cell_data[0];
                    end
                end
                REQ_WALK_BEGIN:
                begin
                    // snapshot the stored entries into the walk chain
                    ctrl.walk_copy = 1'b1;
                    walk_left_next = fill_reg;
                    res_ok         = 1'b1;
                end
                REQ_WALK_NEXT:
                begin
                    if (walk_left_reg != '0)
                    begin
                        ctrl.walk_shift = 1'b1;
                        walk_left_next  = walk_left_reg - 1'b1;
                        res_ok          = 1'b1;
                        res_data        = cell_walk[0];
                    end
                end
                REQ_WALK_END:
                begin
                    walk_left_next = '0;
                    res_ok         = 1'b1;
                end
                default:
                begin
                    res_ok = 1'b0;
                end
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_data;
            logic [DATA_WIDTH-1:0] right_data;
            logic [DATA_WIDTH-1:0] right_walk;

            if (gi == 0)
            begin : g_head
                assign left_data = data_in;
            end
            else
            begin : g_body
                assign left_data = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_data = cell_data[gi];
                assign right_walk = cell_walk[gi];
            end
            else
            begin : g_inner
                assign right_data = cell_data[gi+1];
                assign right_walk = cell_walk[gi+1];
            end

            bdq_cell #(
                .DEPTH      (DEPTH),
                .DATA_WIDTH (DATA_WIDTH),
                .INDEX      (gi)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .fill       (fill_reg),
                .new_data   (data_in),
                .left_data  (left_data),
                .right_data (right_data),
                .right_walk (right_walk),
                .data       (cell_data[gi]),
                .walk       (cell_walk[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            walk_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            walk_left_reg <= walk_left_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_ok_reg   <= res_ok;
            out_data_reg <= res_data;
            out_fill_reg <= fill_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_ok_reg;
    assign m_axis_tdata  = OW'({out_fill_reg, out_data_reg});

    `BDQ_ASSERT_ALWAYS(a_fill_bound, fill_reg <= FW'(DEPTH), "fill above depth")
    `BDQ_ASSERT_ALWAYS(a_walk_bound, walk_left_reg <= fill_reg, "walk longer than store")
    `BDQ_ASSERT_NEXT(a_push_grows,
        accept && !full && (req == REQ_PUSH_BACK || req == REQ_PUSH_FRONT),
        fill_reg == $past(fill_reg) + 1'b1, "push did not grow fill")
    `BDQ_ASSERT_NEXT(a_walk_ends,
        accept && (req == REQ_PUSH_BACK || req == REQ_PUSH_FRONT || req == REQ_POP_FRONT),
        walk_left_reg == '0, "walk survived push or pop")
    `BDQ_ASSERT_ALWAYS(a_fail_zero, !(out_valid_reg && !out_ok_reg) || out_data_reg == '0,
        "failed result carries data")

endmodule

/* test/bounded_deque_with_walk_tb.sv */
// Self-checking testbench for the bounded deque with walk: directed and random request streams.
`timescale 1ns / 100ps

module bounded_deque_with_walk_tb;
    import bdq_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int DW          = DATA_WIDTH_DEFAULT;
    localparam int FILL_W      = $clog2(DEPTH + 1);
    localparam int S_TDATA_W   = ((DW + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((DW + FILL_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD_AT     = 200;
    localparam int LONG_HOLD_CYCLES = 80;

    // Request codes the block does not define; it must answer them with ok low.
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    typedef struct {
        logic              ok;
        logic [DW-1:0]     value;
        logic [FILL_W-1:0] level;
    } deque_result_t;

    class deque_scoreboard;
        logic [DW-1:0] slot_mem [DEPTH];
        int            head_slot  = 0;
        int            fill_count = 0;
        int            walk_slot  = 0;
        int            walk_left  = 0;
        int            errors     = 0;
        deque_result_t expected_results [$];

        function int pending_count();
            return expected_results.size();
        endfunction

        // Advance the deque state by one accepted request and queue its answer.
        function void note_request(logic [2:0] req, logic [DW-1:0] value);
            deque_result_t r;
            int            pos;
            r.ok    = 1'b0;
            r.value = '0;
            case (req)
                REQ_PUSH_BACK:
                begin
                    walk_left = 0;
                    if (fill_count < DEPTH)
                    begin
                        pos = (head_slot + fill_count) % DEPTH;
                        slot_mem[pos] = value;
                        fill_count++;
                        r.ok = 1'b1;
                    end
                end
                REQ_PUSH_FRONT:
                begin
                    walk_left = 0;
                    if (fill_count < DEPTH)
                    begin
                        head_slot = (head_slot + DEPTH - 1) % DEPTH;
                        slot_mem[head_slot] = value;
                        fill_count++;
                        r.ok = 1'b1;
                    end
                end
                REQ_POP_FRONT:
                begin
                    walk_left = 0;
                    if (fill_count > 0)
                    begin
                        r.value   = slot_mem[head_slot];
                        head_slot = (head_slot + 1) % DEPTH;
                        fill_count--;
                        r.ok = 1'b1;
                    end
                end
                REQ_WALK_BEGIN:
                begin
                    walk_slot = head_slot;
                    walk_left = fill_count;
                    r.ok      = 1'b1;
                end
                REQ_WALK_NEXT:
                begin
                    if (walk_left > 0)
                    begin
                        r.value   = slot_mem[walk_slot];
                        walk_slot = (walk_slot + 1) % DEPTH;
                        walk_left--;
                        r.ok = 1'b1;
                    end
                end
                REQ_WALK_END:
                begin
                    walk_left = 0;
                    r.ok      = 1'b1;
                end
                default:
                begin
                end
            endcase
            r.level = fill_count[FILL_W-1:0];
            expected_results.push_back(r);
        endfunction

        function void check_result(logic ok, logic [DW-1:0] value, logic [FILL_W-1:0] level);
            deque_result_t r;
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected: ok=%0d data_out=%h fill_level=%0d",
                       ok, value, level);
                errors++;
                return;
            end
            r = expected_results.pop_front();
            if (ok !== r.ok)
            begin
                $error("ok mismatch: expected %0d, actual %0d", r.ok, ok);
                errors++;
            end
            if (value !== r.value)
            begin
                $error("data_out mismatch: expected %h, actual %h", r.value, value);
                errors++;
            end
            if (level !== r.level)
            begin
                $error("fill_level mismatch: expected %0d, actual %0d", r.level, level);
                errors++;
            end
        endfunction
    endclass

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [2:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    deque_scoreboard sb;
    int  items_sent      = 0;
    int  words_taken     = 0;
    int  cycle_count     = 0;
    bit  tx_idle_on      = 1'b0;
    bit  rx_idle_on      = 1'b0;
    bit  long_hold_done  = 1'b0;

    bounded_deque_with_walk u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("bounded_deque_with_walk verification failed");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_request(logic [2:0] req, logic [DW-1:0] value);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= S_TDATA_W'(value);
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(req, value);
        if (req <= REQ_WALK_END)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_count() != 0)
            @(negedge clk);
    endtask

    function automatic logic [DW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return DW'($urandom());
        endcase
    endfunction

    function automatic logic [2:0] pick_update();
        case ($urandom_range(0, 2))
            0:       return REQ_PUSH_BACK;
            1:       return REQ_PUSH_FRONT;
            default: return REQ_POP_FRONT;
        endcase
    endfunction

    task automatic run_directed();
        send_request(REQ_WALK_NEXT, 32'h1234_5678);
        send_request(REQ_WALK_END, '0);
        send_request(REQ_POP_FRONT, '1);
        send_request(REQ_SPARE_LO, '1);
        send_request(REQ_SPARE_HI, '0);
        send_request(REQ_WALK_BEGIN, '0);
        send_request(REQ_WALK_NEXT, '0);
        send_request(REQ_PUSH_BACK, '0);
        send_request(REQ_PUSH_FRONT, '1);
        send_request(REQ_PUSH_BACK, 32'hA5A5_A5A5);
        send_request(REQ_WALK_BEGIN, '0);
        send_request(REQ_WALK_NEXT, '0);
        // restart mid-walk, then walk past the last entry
        send_request(REQ_WALK_BEGIN, '0);
        repeat (4) send_request(REQ_WALK_NEXT, '0);
        send_request(REQ_WALK_BEGIN, '0);
        send_request(REQ_WALK_NEXT, '0);
        // a push ends the walk
        send_request(REQ_PUSH_BACK, 32'h5A5A_5A5A);
        send_request(REQ_WALK_NEXT, '0);
        // so does a pop
        send_request(REQ_WALK_BEGIN, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_WALK_NEXT, '0);
        send_request(REQ_WALK_END, '0);
    endtask

    task automatic run_random(int target);
        int n;
        while (items_sent < target)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // fill to the brim, then push into the full store up to twice
                    while (sb.fill_count < DEPTH)
                        send_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                                     pick_value());
                    repeat ($urandom_range(0, 2))
                        send_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                                     pick_value());
                end
                2:
                begin
                    while (sb.fill_count > 0)
                        send_request(REQ_POP_FRONT, pick_value());
                    repeat ($urandom_range(0, 2))
                        send_request(REQ_POP_FRONT, pick_value());
                end
                3, 4, 5:
                begin
                    send_request(REQ_WALK_BEGIN, pick_value());
                    n = sb.fill_count + $urandom_range(0, 2);
                    for (int i = 0; i < n; i++)
                    begin
                        if ($urandom_range(0, 11) == 0)
                        begin
                            case ($urandom_range(0, 2))
                                0:       send_request(pick_update(), pick_value());
                                1:       send_request(REQ_WALK_BEGIN, pick_value());
                                default: send_request(REQ_WALK_END, pick_value());
                            endcase
                        end
                        else
                            send_request(REQ_WALK_NEXT, pick_value());
                    end
                    if ($urandom_range(0, 1))
                        send_request(REQ_WALK_END, pick_value());
                end
                6, 7:
                begin
                    repeat ($urandom_range(1, 6))
                        send_request(pick_update(), pick_value());
                end
                default:
                begin
                    repeat ($urandom_range(1, 4))
                        send_request(3'($urandom_range(0, 7)), pick_value());
                end
            endcase
        end
    endtask

    // Result side: draw a stall per word, take it, check it.
    initial
    begin
        int stall;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            stall = rx_idle_on ? $urandom_range(0, 5) : 0;
            if (words_taken >= LONG_HOLD_AT && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                stall = LONG_HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            sb.check_result(m_axis_tuser, m_axis_tdata[DW-1:0], m_axis_tdata[DW +: FILL_W]);
            words_taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        sb = new;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        wait_drained();

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random(150);
        wait_drained();

        // back-to-back on both sides; the long receiver hold lands here
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(300);
        wait_drained();

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random(450);
        wait_drained();
        repeat (20) @(negedge clk);

        if (sb.errors == 0)
            $display("bounded_deque_with_walk verification clean");
        else
            $display("bounded_deque_with_walk verification failed");
        $finish;
    end

endmodule
